### rtl/dxt_pkg.sv
// Package with the shared types, constants and divide helpers of the block decoder.
package dxt_pkg;

    localparam int PIX_W     = 4;
    localparam logic [PIX_W-1:0] LAST_PIXEL = 4'd15;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [1:0] {
        MODE_DXT1  = 2'd0,
        MODE_DXT1A = 2'd1,
        MODE_DXT3  = 2'd2,
        MODE_DXT5  = 2'd3
    } dxt_mode_t;

    // Decoded block: palettes and per-pixel codes, ready for pixel selection.
    typedef struct packed {
        logic [3:0][23:0] color_pal;   // each entry {blue, green, red}
        logic             trans3;      // entry 3 is transparent black
        logic [7:0][7:0]  alpha_pal;
        logic [31:0]      color_sel;
        logic [63:0]      alpha_bits;
    } blk_state_t;

    // x / 3 for x < 768 by multiplication with a reciprocal.
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

    // x / 5 for x < 1280.
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [23:0] p;
        p = 24'(x) * 24'd1639;
        return p[20:13];
    endfunction

    // x / 7 for x < 1792.
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd2341;
        return p[21:14];
    endfunction

endpackage

### rtl/dxt_palette.sv
// Builds the colour and alpha palettes of one compressed block.
module dxt_palette
(
    input  dxt_pkg::dxt_mode_t  mode,
    input  logic [63:0]         alpha_word,
    input  logic [63:0]         color_word,
    output dxt_pkg::blk_state_t blk
);
    import dxt_pkg::*;

    logic        dxt1;
    logic [63:0] cw;
    logic [15:0] e0;
    logic [15:0] e1;
    logic [2:0][7:0] c0;
    logic [2:0][7:0] c1;
    logic [2:0][7:0] mid2;
    logic [2:0][7:0] mid3;
    logic        three_col;
    logic [7:0]  a0;
    logic [7:0]  a1;

    assign dxt1 = (mode == MODE_DXT1) || (mode == MODE_DXT1A);
    assign cw   = dxt1 ? alpha_word : color_word;
    assign e0   = cw[15:0];
    assign e1   = cw[31:16];
    assign three_col = dxt1 && (e0 <= e1);

    // Channel order is red, green, blue; endpoints widen by top-bit replication.
    assign c0[0] = {e0[15:11], e0[15:13]};
    assign c0[1] = {e0[10:5],  e0[10:9]};
    assign c0[2] = {e0[4:0],   e0[4:2]};
    assign c1[0] = {e1[15:11], e1[15:13]};
    assign c1[1] = {e1[10:5],  e1[10:9]};
    assign c1[2] = {e1[4:0],   e1[4:2]};

    always_comb
    begin
        logic [8:0] sum;
        for (int i = 0; i < 3; i++)
        begin
            sum = {1'b0, c0[i]} + {1'b0, c1[i]};
            if (three_col)
            begin
                mid2[i] = sum[8:1];
                mid3[i] = 8'd0;
            end
            else
            begin
                mid2[i] = div3({1'b0, c0[i], 1'b0} + {2'b0, c1[i]} + 10'd1);
                mid3[i] = div3({2'b0, c0[i]} + {1'b0, c1[i], 1'b0} + 10'd1);
            end
        end
    end

    assign a0 = alpha_word[7:0];
    assign a1 = alpha_word[15:8];

    always_comb
    begin
        blk.color_pal[0] = {c0[2], c0[1], c0[0]};
        blk.color_pal[1] = {c1[2], c1[1], c1[0]};
        blk.color_pal[2] = {mid2[2], mid2[1], mid2[0]};
        blk.color_pal[3] = {mid3[2], mid3[1], mid3[0]};
        blk.trans3       = three_col && (mode == MODE_DXT1A);
        blk.color_sel    = cw[63:32];
        blk.alpha_bits   = (mode == MODE_DXT5) ? {16'd0, alpha_word[63:16]} : alpha_word;
        blk.alpha_pal[0] = a0;
        blk.alpha_pal[1] = a1;
        if (a0 > a1)
        begin
            for (int k = 1; k <= 6; k++)
            begin
                blk.alpha_pal[k+1] = div7(11'(7 - k) * {3'd0, a0} + 11'(k) * {3'd0, a1}
                                          + 11'd3);
            end
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
            begin
                blk.alpha_pal[k+1] = div5(11'(5 - k) * {3'd0, a0} + 11'(k) * {3'd0, a1}
                                          + 11'd2);
            end
            blk.alpha_pal[6] = 8'd0;
            blk.alpha_pal[7] = ALPHA_OPAQUE;
        end
    end

endmodule

### rtl/dxt_block_decoder.sv
// Top level of the S3TC block decoder: input register, block palette stage, pixel output.
//
// Decodes one compressed 4x4 block (DXT1, DXT1 with one-bit alpha, DXT3 or DXT5, chosen by
// the format register) into 16 RGBA pixels in raster order, one pixel per cycle while the
// output is not stalled, with m_tlast on pixel 15. Pixels leave through the single pixel
// output register; an accepted block passes the input register and the block register
// before its first pixel is loaded into the output register. One block waits in the input
// register while the previous one is being emitted. The format register must only be
// written while no block is in flight.
module dxt_block_decoder
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wen,
    input  logic [1:0]   cfg_wdata,    // format_mode
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,      // alpha_word [63:0], color_word [127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,      // red, green, blue, alpha, pixel_index, zero pad
    output logic         m_tlast
);
    import dxt_pkg::*;

    dxt_mode_t   mode_reg;
    logic        in_vld_reg;
    logic [63:0] aw_reg;
    logic [63:0] cw_reg;
    logic        blk_vld_reg;
    blk_state_t  blk_reg;
    blk_state_t  blk_next;
    logic [PIX_W-1:0] cnt_reg;
    logic        out_vld_reg;
    logic [39:0] out_data_reg;
    logic        out_last_reg;

    logic        issue;
    logic        blk_done;
    logic        blk_load;
    logic [1:0]  sel;
    logic [23:0] rgb;
    logic [3:0]  nib;
    logic [2:0]  acode;
    logic [7:0]  alpha_px;
    logic [39:0] pix_data;

    dxt_palette u_palette
    (
        .mode       (mode_reg),
        .alpha_word (aw_reg),
        .color_word (cw_reg),
        .blk        (blk_next)
    );

    assign issue    = blk_vld_reg && (!out_vld_reg || m_tready);
    assign blk_done = issue && (cnt_reg == LAST_PIXEL);
    assign blk_load = in_vld_reg && (!blk_vld_reg || blk_done);
    assign s_tready = !in_vld_reg || blk_load;

    // Pixel selection for the current counter position.
    assign sel   = blk_reg.color_sel[{cnt_reg, 1'b0} +: 2];
    assign rgb   = blk_reg.color_pal[sel];
    assign nib   = blk_reg.alpha_bits[{cnt_reg, 2'b00} +: 4];
    assign acode = blk_reg.alpha_bits[6'(cnt_reg) * 6'd3 +: 3];

    always_comb
    begin
        unique case (mode_reg)
            MODE_DXT1:  alpha_px = ALPHA_OPAQUE;
            MODE_DXT1A: alpha_px = (blk_reg.trans3 && (sel == 2'd3)) ? 8'd0 : ALPHA_OPAQUE;
            MODE_DXT3:  alpha_px = {nib, nib};
            MODE_DXT5:  alpha_px = blk_reg.alpha_pal[acode];
            default:    alpha_px = ALPHA_OPAQUE;
        endcase
    end

    assign pix_data = {4'd0, cnt_reg, alpha_px, rgb};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_DXT1;
            in_vld_reg  <= 1'b0;
            blk_vld_reg <= 1'b0;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                mode_reg <= dxt_mode_t'(cfg_wdata);
            end
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (blk_load)
            begin
                blk_vld_reg <= 1'b1;
            end
            else if (blk_done)
            begin
                blk_vld_reg <= 1'b0;
            end
            if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (issue)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            aw_reg <= s_tdata[63:0];
            cw_reg <= s_tdata[127:64];
        end
        if (blk_load)
        begin
            blk_reg <= blk_next;
        end
        if (issue)
        begin
            out_data_reg <= pix_data;
            out_last_reg <= (cnt_reg == LAST_PIXEL);
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

### sim/tb_dxt_block_decoder.sv
// Self-checking testbench for the S3TC block decoder: random and directed blocks in all formats.
module tb_dxt_block_decoder;
    import dxt_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BLOCKS = 32;
    localparam int DRAIN_CYCLES  = 8;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [PIX_W-1:0] pixel_index;
        logic             last;
    } pixel_t;

    class pixel_scoreboard;
        dxt_mode_t format;
        int        errors;
        pixel_t    expected_pixels[$];

        function new();
            format = MODE_DXT1;
            errors = 0;
        endfunction

        // Decodes one accepted block into the sixteen pixels it must produce.
        function void note_block(logic [63:0] aw, logic [63:0] cw);
            logic [63:0] cpart;
            logic [63:0] codes;
            logic [15:0] ep[2];
            int unsigned rgb[4][3];
            int unsigned apal[8];
            int unsigned a0;
            int unsigned a1;
            int unsigned s;
            bit          is_dxt1;
            bit          three_color;
            pixel_t      px;

            is_dxt1     = (format == MODE_DXT1) || (format == MODE_DXT1A);
            cpart       = is_dxt1 ? aw : cw;
            ep[0]       = cpart[15:0];
            ep[1]       = cpart[31:16];
            three_color = is_dxt1 && (ep[0] <= ep[1]);
            for (int e = 0; e < 2; e++)
            begin
                rgb[e][0] = {ep[e][15:11], ep[e][15:13]};
                rgb[e][1] = {ep[e][10:5], ep[e][10:9]};
                rgb[e][2] = {ep[e][4:0], ep[e][4:2]};
            end
            for (int c = 0; c < 3; c++)
            begin
                if (three_color)
                begin
                    rgb[2][c] = (rgb[0][c] + rgb[1][c]) / 2;
                    rgb[3][c] = 0;
                end
                else
                begin
                    rgb[2][c] = (2 * rgb[0][c] + rgb[1][c] + 1) / 3;
                    rgb[3][c] = (rgb[0][c] + 2 * rgb[1][c] + 1) / 3;
                end
            end

            a0      = aw[7:0];
            a1      = aw[15:8];
            apal[0] = a0;
            apal[1] = a1;
            if (a0 > a1)
            begin
                for (int k = 1; k <= 6; k++)
                    apal[k+1] = ((7 - k) * a0 + k * a1 + 3) / 7;
            end
            else
            begin
                for (int k = 1; k <= 4; k++)
                    apal[k+1] = ((5 - k) * a0 + k * a1 + 2) / 5;
                apal[6] = 0;
                apal[7] = 255;
            end

            // In DXT5 the 3-bit codes start right after the two alpha endpoints.
            codes = (format == MODE_DXT5) ? (aw >> 16) : aw;
            for (int p = 0; p < 16; p++)
            begin
                s        = cpart[32 + 2*p +: 2];
                px.red   = rgb[s][0][7:0];
                px.green = rgb[s][1][7:0];
                px.blue  = rgb[s][2][7:0];
                case (format)
                    MODE_DXT1:  px.alpha = ALPHA_OPAQUE;
                    MODE_DXT1A: px.alpha = (three_color && s == 3) ? 8'h00 : ALPHA_OPAQUE;
                    MODE_DXT3:  px.alpha = {2{codes[4*p +: 4]}};
                    default:    px.alpha = apal[codes[3*p +: 3]][7:0];
                endcase
                px.pixel_index = p[PIX_W-1:0];
                px.last        = (p[PIX_W-1:0] == LAST_PIXEL);
                expected_pixels.push_back(px);
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_pixel(logic [39:0] data, logic tlast);
            pixel_t got;
            pixel_t want;

            got = {data[7:0], data[15:8], data[23:16], data[31:24], data[35:32], tlast};
            if (expected_pixels.size() == 0)
            begin
                errors++;
                $display("%0t: pixel transaction %h with nothing expected, expected none, actual %h",
                         $time, data, data);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("pixel_index", want.pixel_index, got.pixel_index);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_wen;
    logic [1:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic         m_tlast;

    pixel_scoreboard pixel_sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count = 0;

    logic [63:0] directed_alpha[6] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hE4E4_E4E4_FFFF_0000,
        64'hE4E4_E4E4_F800_07E0, 64'hFAC6_88FA_C688_FF00, 64'h1B1B_1B1B_7BEF_7BEF
    };
    logic [63:0] directed_color[6] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hE4E4_E4E4_001F_F800,
        64'hE4E4_E4E4_FFFF_0000, 64'h5555_AAAA_1234_1234, 64'hFAC6_88FA_C688_40C0
    };

    dxt_block_decoder i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            pixel_sb.check_pixel(m_tdata, m_tlast);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[dxt_block_decoder] ERROR");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_block(input logic [63:0] aw, input logic [63:0] cw);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {cw, aw};
        do
            @(posedge clk);
        while (!s_tready);
        pixel_sb.note_block(aw, cw);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pixel_sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_format(input dxt_mode_t mode);
        wait_drained();
        cfg_wen   = 1'b1;
        cfg_wdata = mode;
        @(negedge clk);
        cfg_wen = 1'b0;
        pixel_sb.format = mode;
    endtask

    // Random block whose endpoints are often equal or in three-colour order.
    task automatic random_block(input dxt_mode_t mode, output logic [63:0] aw,
                                output logic [63:0] cw);
        logic [63:0] cpart;
        logic [15:0] tmp;
        int          pick;

        aw    = {$urandom, $urandom};
        cw    = {$urandom, $urandom};
        cpart = (mode == MODE_DXT1 || mode == MODE_DXT1A) ? aw : cw;
        pick  = $urandom_range(0, 7);
        if (pick == 0)
            cpart[31:16] = cpart[15:0];
        else if (pick <= 3 && cpart[15:0] > cpart[31:16])
        begin
            tmp           = cpart[15:0];
            cpart[15:0]   = cpart[31:16];
            cpart[31:16]  = tmp;
        end
        if (mode == MODE_DXT1 || mode == MODE_DXT1A)
            aw = cpart;
        else
        begin
            cw = cpart;
            if ($urandom_range(0, 7) == 0)
                aw[15:8] = aw[7:0];
        end
    endtask

    initial
    begin
        logic [63:0] aw;
        logic [63:0] cw;
        dxt_mode_t   phase_modes[3][4];
        dxt_mode_t   mode;

        phase_modes = '{'{MODE_DXT1A, MODE_DXT5, MODE_DXT1, MODE_DXT3},
                        '{MODE_DXT3, MODE_DXT1, MODE_DXT5, MODE_DXT1A},
                        '{MODE_DXT5, MODE_DXT3, MODE_DXT1A, MODE_DXT1}};
        pixel_sb      = new();
        rst_n         = 1'b0;
        cfg_wen       = 1'b0;
        cfg_wdata     = MODE_DXT1;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        send_idle_pct = 25;
        recv_idle_pct = 51;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int m = 0; m < 4; m++)
        begin
            write_format(dxt_mode_t'(m));
            for (int d = 0; d < 6; d++)
                send_block(directed_alpha[d], directed_color[d]);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_drained();
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 51 : 0;
            recv_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 25 : 0;
            for (int m = 0; m < 4; m++)
            begin
                mode = phase_modes[phase][m];
                write_format(mode);
                for (int n = 0; n < RANDOM_BLOCKS; n++)
                begin
                    random_block(mode, aw, cw);
                    send_block(aw, cw);
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (pixel_sb.errors == 0 && pixel_sb.pending() == 0)
            $display("[dxt_block_decoder] OK");
        else
            $display("[dxt_block_decoder] ERROR");
        $finish;
    end

endmodule

### filelist.f
rtl/dxt_pkg.sv
rtl/dxt_palette.sv
rtl/dxt_block_decoder.sv
sim/tb_dxt_block_decoder.sv
